[src/nmtp_pkg.sv]
// Shared types, codes and helper functions of the netmask text parser.
package nmtp_pkg;

    localparam logic [1:0] KIND_HOST = 2'd0;
    localparam logic [1:0] KIND_V4   = 2'd1;
    localparam logic [1:0] KIND_V6   = 2'd2;

    localparam logic REG_IPV6_EN = 1'b0;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    // largest octet accumulator that still takes a digit of five or less
    localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;

    typedef struct packed {
        logic              v4_bad;
        logic              v4_slash;
        logic              v4_star;
        logic              v6_bad;
        logic              v6_slash;
        logic              v6_star;
        logic              gap;
        logic              colon;
        logic              dot;
        logic [2:0]        cnt;
        logic [3:0][7:0]   oct;
        logic [7:0]        p4;
        logic [7:0][15:0]  hw;
        logic [3:0]        dp;
        logic [2:0]        gp;
        logic [7:0]        p6;
    } t_snap;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  plen;
    } t_result;

    function automatic logic [7:0] sat_digit(input logic [7:0] v, input logic [3:0] d);
        logic [11:0] n;
        n = {4'b0, v} * 12'd10 + {8'b0, d};
        return (n > 12'd255) ? 8'hFF : n[7:0];
    endfunction

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[src/ip_netmask_text_parser_unit.sv]
// Top level of the netmask text parser: handshakes, configuration register and pipeline.
//
// Feed a mask string one character per request on the input channel, with
// i_last_char high on its final character. One result request follows each
// final character: o_mask_kind is hostname, IPv4 or IPv6, with the masked
// address and prefix length (all zero for a hostname). Other characters give
// no result.
// An input request is taken every cycle while no final character is held up.
// A character passes an input register and updates the parse state; a final
// character also loads a snapshot register, whose classification moves on into
// the output register, from which the result is offered. One string can end in
// every cycle while the receiver takes each result.
// When the receiver stalls, the result holds in the output register and the
// snapshot register fills behind it; ordinary characters keep flowing, and
// input stops only when a final character finds no free snapshot slot.
// Reset (synchronous) empties the pipeline, clears the parse state and sets
// ipv6_enable. ipv6_enable is register 0 on the APB port, bit 0.
module ip_netmask_text_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_mask_kind,
    output logic [63:0] o_address_high,
    output logic [63:0] o_address_low,
    output logic [7:0]  o_prefix_len,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nmtp_pkg::*;

    logic       r_ipv6_en;
    logic       r_in_valid, r_in_last;
    logic [7:0] r_in_char;
    logic       r_snap_valid;
    t_snap      r_snap, snap;
    logic       r_out_valid;
    t_result    r_out, fin;
    logic       out_ready, snap_ready, snap_adv, in_fire;

    assign out_ready  = !r_out_valid || i_ready;
    assign snap_adv   = r_snap_valid && out_ready;
    assign snap_ready = !r_snap_valid || out_ready;
    assign in_fire    = r_in_valid && (!r_in_last || snap_ready);
    assign o_ready    = !r_in_valid || in_fire;

    nmtp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_snap  (snap)
    );

    nmtp_finish u_finish (
        .i_snap    (r_snap),
        .i_ipv6_en (r_ipv6_en),
        .o_result  (fin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_fire && r_in_last) begin
            r_snap_valid <= 1'b1;
        end else if (snap_adv) begin
            r_snap_valid <= 1'b0;
        end
        if (in_fire && r_in_last) begin
            r_snap <= snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (snap_adv) begin
            r_out <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipv6_en <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_IPV6_EN) begin
            r_ipv6_en <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IPV6_EN) ? {31'b0, r_ipv6_en} : 32'b0;

    assign o_valid        = r_out_valid;
    assign o_mask_kind    = r_out.kind;
    assign o_address_high = r_out.hi;
    assign o_address_low  = r_out.lo;
    assign o_prefix_len   = r_out.plen;

    a_no_v6_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ipv6_en |-> o_mask_kind != KIND_V6)
        else $error("IPv6 result while IPv6 is disabled");

    a_host_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_mask_kind == KIND_HOST |->
            o_address_high == 64'b0 && o_address_low == 64'b0 && o_prefix_len == 8'd0)
        else $error("hostname result carries address data");

    a_v4_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_mask_kind == KIND_V4 |->
            o_prefix_len != 8'd0 && o_prefix_len <= 8'd32 && o_address_high == 64'b0)
        else $error("IPv4 result out of range");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid && !out_ready |=> r_snap_valid && $stable(r_snap))
        else $error("snapshot lost under stall");

endmodule

[src/nmtp_step.sv]
// Per-character parse state of the IPv4 and IPv6 parsers, and the end-of-string snapshot.
module nmtp_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    output nmtp_pkg::t_snap o_snap
);
    import nmtp_pkg::*;

    logic [3:0][7:0]  r_oct, n_oct;
    logic [63:0]      r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic [2:0]       r_cnt, n_cnt;
    logic [7:0][15:0] r_hw, n_hw;
    logic [3:0]       r_widx, n_widx;
    logic [2:0]       r_nib, n_nib;
    logic [2:0]       r_gp, n_gp;
    logic [7:0]       r_p4, n_p4;
    logic [7:0]       r_p6, n_p6;
    logic [7:0]       r_prev, n_prev;
    logic r_v4_bad, r_v4_slash, r_v4_star, r_v6_bad, r_v6_slash, r_v6_star;
    logic r_gap, r_colon, r_dot;
    logic n_v4_bad, n_v4_slash, n_v4_star, n_v6_bad, n_v6_slash, n_v6_star;
    logic n_gap, n_colon, n_dot;

    logic       is_dig;
    logic [3:0] dig;
    logic [4:0] hv;
    logic [7:0] cv;
    logic [1:0] ci;
    logic [2:0] wi;

    assign is_dig = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign dig    = i_char[3:0];
    assign hv     = hex_val(i_char);
    assign cv     = r_ovf ? 8'hFF : r_acc[7:0];
    assign ci     = r_cnt[1:0] - 2'd1;
    assign wi     = r_widx[2:0];

    always_comb begin
        n_oct = r_oct;   n_acc = r_acc;   n_ovf = r_ovf;   n_cnt = r_cnt;
        n_hw = r_hw;     n_widx = r_widx; n_nib = r_nib;   n_gp = r_gp;
        n_p4 = r_p4;     n_p6 = r_p6;     n_prev = i_char;
        n_v4_bad = r_v4_bad; n_v4_slash = r_v4_slash; n_v4_star = r_v4_star;
        n_v6_bad = r_v6_bad; n_v6_slash = r_v6_slash; n_v6_star = r_v6_star;
        n_gap = r_gap;
        n_colon = r_colon | (i_char == CH_COLON);
        n_dot   = r_dot | (i_char == CH_DOT);

        // IPv4
        if (r_v4_bad || r_v4_star) begin
            n_v4_bad = 1'b1;
        end else if (r_v4_slash) begin
            if (is_dig) n_p4 = sat_digit(r_p4, dig);
            else        n_v4_bad = 1'b1;
        end else if (is_dig) begin
            if (r_acc > ACC_LIMIT || (r_acc == ACC_LIMIT && dig >= 4'd6)) n_ovf = 1'b1;
            n_acc = (r_acc << 3) + (r_acc << 1) + {60'b0, dig};
        end else if (i_char == CH_DOT) begin
            if (r_cnt >= 3'd4) begin
                n_v4_bad = 1'b1;
            end else begin
                n_oct[ci] = cv;
                n_acc = 64'b0;
                n_ovf = 1'b0;
                n_cnt = r_cnt + 3'd1;
            end
        end else if (i_char == CH_STAR) begin
            if (r_prev != CH_DOT) n_v4_bad = 1'b1;
            else                  n_v4_star = 1'b1;
        end else if (i_char == CH_SLASH) begin
            n_oct[ci] = cv;
            n_acc = 64'b0;
            n_ovf = 1'b0;
            n_v4_slash = 1'b1;
        end else begin
            n_v4_bad = 1'b1;
        end

        // IPv6
        if (r_v6_bad || r_v6_star) begin
            n_v6_bad = 1'b1;
        end else if (r_v6_slash) begin
            if (is_dig) n_p6 = sat_digit(r_p6, dig);
            else        n_v6_bad = 1'b1;
        end else if (hv[4]) begin
            if (r_nib == 3'd0) begin
                n_v6_bad = 1'b1;
            end else begin
                n_nib = r_nib - 3'd1;
                n_hw[wi] = r_hw[wi] | ({12'b0, hv[3:0]} << {n_nib[1:0], 2'b00});
            end
        end else if (i_char == CH_COLON) begin
            if (r_prev == CH_COLON) begin
                if (r_gap) begin
                    n_v6_bad = 1'b1;
                end else begin
                    n_gp  = wi;
                    n_gap = 1'b1;
                end
            end else begin
                n_hw[wi] = r_hw[wi] >> {r_nib, 2'b00};
                n_nib    = 3'd4;
                n_widx   = r_widx + 4'd1;
                if (n_widx >= 4'd8) n_v6_bad = 1'b1;
            end
        end else if (i_char == CH_STAR) begin
            if (r_gap || r_widx == 4'd0 || r_prev != CH_COLON) begin
                n_v6_bad = 1'b1;
            end else begin
                n_v6_star = 1'b1;
                n_p6 = {r_widx, 4'b0};
            end
        end else if (i_char == CH_SLASH) begin
            n_hw[wi] = r_hw[wi] >> {r_nib, 2'b00};
            n_widx   = r_widx + 4'd1;
            if (r_prev == CH_COLON) begin
                n_v6_bad = 1'b1;
            end else begin
                n_v6_slash = 1'b1;
                n_p6 = 8'd0;
            end
        end else begin
            n_v6_bad = 1'b1;
        end
    end

    // close the open octet and hex word for the end of the string
    always_comb begin
        o_snap = '0;
        o_snap.v4_bad = n_v4_bad;  o_snap.v4_slash = n_v4_slash; o_snap.v4_star = n_v4_star;
        o_snap.v6_bad = n_v6_bad;  o_snap.v6_slash = n_v6_slash; o_snap.v6_star = n_v6_star;
        o_snap.gap = n_gap;        o_snap.colon = n_colon;       o_snap.dot = n_dot;
        o_snap.cnt = n_cnt;
        o_snap.oct = n_oct;
        if (!n_v4_slash && !n_v4_star) begin
            o_snap.oct[n_cnt[1:0] - 2'd1] = n_ovf ? 8'hFF : n_acc[7:0];
        end
        o_snap.p4 = n_p4;
        o_snap.hw = n_hw;
        o_snap.dp = n_widx;
        if (!n_v6_slash) begin
            o_snap.hw[n_widx[2:0]] = n_hw[n_widx[2:0]] >> {n_nib, 2'b00};
            o_snap.dp = n_widx + 4'd1;
        end
        o_snap.gp = n_gp;
        o_snap.p6 = n_p6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_oct <= '0;  r_acc <= '0;  r_ovf <= 1'b0;  r_cnt <= 3'd1;
            r_hw <= '0;   r_widx <= '0; r_nib <= 3'd4;  r_gp <= '0;
            r_p4 <= '0;   r_p6 <= '0;   r_prev <= '0;
            r_v4_bad <= 1'b0; r_v4_slash <= 1'b0; r_v4_star <= 1'b0;
            r_v6_bad <= 1'b0; r_v6_slash <= 1'b0; r_v6_star <= 1'b0;
            r_gap <= 1'b0;    r_colon <= 1'b0;    r_dot <= 1'b0;
        end else if (i_fire) begin
            r_oct <= n_oct;   r_acc <= n_acc;   r_ovf <= n_ovf;  r_cnt <= n_cnt;
            r_hw <= n_hw;     r_widx <= n_widx; r_nib <= n_nib;  r_gp <= n_gp;
            r_p4 <= n_p4;     r_p6 <= n_p6;     r_prev <= n_prev;
            r_v4_bad <= n_v4_bad; r_v4_slash <= n_v4_slash; r_v4_star <= n_v4_star;
            r_v6_bad <= n_v6_bad; r_v6_slash <= n_v6_slash; r_v6_star <= n_v6_star;
            r_gap <= n_gap;       r_colon <= n_colon;       r_dot <= n_dot;
        end
    end

endmodule

[src/nmtp_finish.sv]
// End-of-string classification, IPv6 gap expansion and prefix masking.
module nmtp_finish (
    input  nmtp_pkg::t_snap   i_snap,
    input  logic              i_ipv6_en,
    output nmtp_pkg::t_result o_result
);
    import nmtp_pkg::*;

    logic [7:0]       bits4, bits6, dp4;
    logic [5:0]       n8;
    logic             ok4, ok6;
    logic [31:0]      addr4;
    logic [8:0]       bsum;
    logic signed [5:0] k;
    logic signed [5:0] sidx [8];
    logic [7:0][15:0] dc;
    logic [127:0]     addr6;

    assign n8 = {i_snap.cnt, 3'b000};
    assign dp4 = {2'b00, i_snap.dp, 2'b00};

    always_comb begin
        if (i_snap.v4_slash)     bits4 = i_snap.p4;
        else if (i_snap.v4_star) bits4 = {2'b00, n8} - 8'd8;
        else                     bits4 = {2'b00, n8};
        ok4 = !i_snap.v4_bad &&
              (!i_snap.v4_slash || (i_snap.p4 != 8'd0 && i_snap.p4 <= {2'b00, n8}));
        addr4 = {i_snap.oct[0], i_snap.oct[1], i_snap.oct[2], i_snap.oct[3]}
                & ~(32'hFFFF_FFFF >> bits4);
    end

    always_comb begin
        if (i_snap.v6_slash || i_snap.v6_star) bits6 = i_snap.p6;
        else if (i_snap.gap)                   bits6 = 8'd128;
        else                                   bits6 = {i_snap.dp, 4'b0000};
        ok6 = !i_snap.v6_bad &&
              (!i_snap.v6_slash ||
               (i_snap.p6 != 8'd0 &&
                !(i_snap.p6 > dp4 && !(i_snap.gap && i_snap.p6 <= 8'd128))));
        bsum = {1'b0, bits6} + 9'd15;
        // words to insert at the gap; negative clears everything from the gap on
        k = $signed({1'b0, bsum[8:4]}) - $signed({2'b00, i_snap.dp});
        for (int i = 0; i < 8; i++) begin
            sidx[i] = $signed(6'(i)) - k;
            if (i_snap.gap && 3'(i) >= i_snap.gp) begin
                if (k < 0 || sidx[i] < $signed({3'b000, i_snap.gp})) dc[i] = 16'h0;
                else dc[i] = i_snap.hw[sidx[i][2:0]];
            end else begin
                dc[i] = i_snap.hw[i];
            end
        end
        addr6 = {dc[0], dc[1], dc[2], dc[3], dc[4], dc[5], dc[6], dc[7]}
                & ~({128{1'b1}} >> bits6);
    end

    always_comb begin
        o_result = '0;
        if (i_snap.colon && i_ipv6_en) begin
            if (ok6) begin
                o_result.kind = KIND_V6;
                o_result.hi   = addr6[127:64];
                o_result.lo   = addr6[63:0];
                o_result.plen = bits6;
            end
        end else if (i_snap.dot) begin
            if (ok4) begin
                o_result.kind = KIND_V4;
                o_result.lo   = {32'b0, addr4};
                o_result.plen = bits4;
            end
        end
    end

endmodule

[test/ip_netmask_text_parser_unit_test.sv]
// Self-checking testbench of the netmask text parser with its own parse predictor.
`timescale 1ns / 100ps

module ip_netmask_text_parser_unit_test;
    import nmtp_pkg::*;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_char_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_char_code;
    logic        i_last_char;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_mask_kind;
    logic [63:0] o_address_high;
    logic [63:0] o_address_low;
    logic [7:0]  o_prefix_len;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ip_netmask_text_parser_unit uut (.*);

    t_char_req pending_chars[$];
    t_result   expected_masks[$];
    int        errors;
    int        send_idle;
    int        recv_idle;

    // predictor state
    logic        v6_en;
    logic [7:0]  oct_val[4];
    logic [63:0] oct_acc;
    logic        oct_ovf;
    int          oct_cnt;
    logic [15:0] hw[8];
    int          widx;
    int          nib;
    int          gpos;
    logic [7:0]  p4;
    logic [7:0]  p6;
    logic        v4_bad, v4_slash, v4_star, v6_bad, v6_slash, v6_star;
    logic        gap_seen, colon_seen, dot_seen;
    logic [7:0]  prev_ch;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic void clear_parse();
        for (int i = 0; i < 4; i++) oct_val[i] = 8'd0;
        for (int i = 0; i < 8; i++) hw[i] = 16'd0;
        oct_acc = 64'd0;
        oct_ovf = 1'b0;
        oct_cnt = 1;
        widx = 0;
        nib = 4;
        gpos = 0;
        p4 = 8'd0;
        p6 = 8'd0;
        {v4_bad, v4_slash, v4_star, v6_bad, v6_slash, v6_star} = '0;
        {gap_seen, colon_seen, dot_seen} = '0;
        prev_ch = 8'd0;
    endfunction

    function automatic logic [7:0] add_digit(logic [7:0] v, logic [7:0] c);
        int n;
        n = int'(v) * 10 + int'(c - CH_ZERO);
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function automatic void commit_octet();
        oct_val[(oct_cnt - 1) & 3] = oct_ovf ? 8'hFF : oct_acc[7:0];
        oct_acc = 64'd0;
        oct_ovf = 1'b0;
    endfunction

    function automatic void close_word();
        logic [31:0] w;
        w = {16'd0, hw[widx & 7]};
        w = w >> (4 * (nib & 7));
        hw[widx & 7] = w[15:0];
    endfunction

    function automatic void step_v4(logic [7:0] c);
        logic digit;
        digit = (c >= CH_ZERO && c <= CH_NINE);
        if (v4_bad || v4_star) begin
            v4_bad = 1'b1;
        end else if (v4_slash) begin
            if (digit) p4 = add_digit(p4, c);
            else v4_bad = 1'b1;
        end else if (digit) begin
            if (oct_acc > (64'hFFFF_FFFF_FFFF_FFFF - (c - CH_ZERO)) / 10) oct_ovf = 1'b1;
            oct_acc = oct_acc * 10 + (c - CH_ZERO);
        end else if (c == CH_DOT) begin
            if (oct_cnt >= 4) begin
                v4_bad = 1'b1;
            end else begin
                commit_octet();
                oct_cnt++;
            end
        end else if (c == CH_STAR) begin
            if (prev_ch != CH_DOT) v4_bad = 1'b1;
            else v4_star = 1'b1;
        end else if (c == CH_SLASH) begin
            commit_octet();
            v4_slash = 1'b1;
        end else begin
            v4_bad = 1'b1;
        end
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LC_A && c <= CH_LC_F) return c - CH_LC_A + 10;
        if (c >= CH_UC_A && c <= CH_UC_F) return c - CH_UC_A + 10;
        return -1;
    endfunction

    function automatic void step_v6(logic [7:0] c);
        int h;
        logic [15:0] hv;
        h = hex_digit(c);
        if (v6_bad || v6_star) begin
            v6_bad = 1'b1;
        end else if (v6_slash) begin
            if (c >= CH_ZERO && c <= CH_NINE) p6 = add_digit(p6, c);
            else v6_bad = 1'b1;
        end else if (h >= 0) begin
            if (nib == 0) begin
                v6_bad = 1'b1;
            end else begin
                nib--;
                hv = 16'(h);
                hw[widx & 7] = hw[widx & 7] | (hv << (4 * nib));
            end
        end else if (c == CH_COLON) begin
            if (prev_ch == CH_COLON) begin
                if (gap_seen) begin
                    v6_bad = 1'b1;
                end else begin
                    gpos = widx;
                    gap_seen = 1'b1;
                end
            end else begin
                close_word();
                nib = 4;
                widx++;
                if (widx >= 8) v6_bad = 1'b1;
            end
        end else if (c == CH_STAR) begin
            if (gap_seen || widx == 0 || prev_ch != CH_COLON) begin
                v6_bad = 1'b1;
            end else begin
                v6_star = 1'b1;
                p6 = 8'(widx * 16);
            end
        end else if (c == CH_SLASH) begin
            close_word();
            widx++;
            if (prev_ch == CH_COLON) begin
                v6_bad = 1'b1;
            end else begin
                v6_slash = 1'b1;
                p6 = 8'd0;
            end
        end else begin
            v6_bad = 1'b1;
        end
    endfunction

    function automatic t_result finish_v4();
        t_result r;
        int n, bits;
        logic [7:0] ob[4];
        r = '0;
        n = oct_cnt;
        bits = 0;
        if (v4_bad) return r;
        if (v4_slash) begin
            bits = p4;
            if (bits == 0 || bits > n * 8) return r;
        end else if (v4_star) begin
            bits = (n - 1) * 8;
        end else begin
            commit_octet();
        end
        if (n < 4 && bits == 0) bits = n * 8;
        if (bits == 0) bits = 32;
        for (int i = 0; i < 4; i++) ob[i] = oct_val[i];
        if (bits < 32 && (bits % 8) != 0) ob[bits / 8] &= 8'hFF << (8 - bits % 8);
        for (int i = (bits + 7) / 8; i < 4; i++) ob[i] = 8'd0;
        r.kind = KIND_V4;
        r.lo = {32'd0, ob[0], ob[1], ob[2], ob[3]};
        r.plen = 8'(bits);
        return r;
    endfunction

    function automatic t_result finish_v6();
        t_result r;
        int bits, src, dp, deficit;
        logic [15:0] dc[8];
        r = '0;
        src = 0;
        dp = widx;
        if (v6_bad) return r;
        if (v6_slash) begin
            bits = p6;
            if (bits == 0) return r;
            if (bits > dp * 4 && !(gap_seen && bits <= 128)) return r;
        end else begin
            close_word();
            dp++;
            bits = v6_star ? int'(p6) : 0;
            if (!gap_seen && bits == 0) bits = dp * 16;
            else if (bits == 0) bits = 128;
        end
        deficit = (bits + 15) / 16 - dp;
        for (int i = 0; i < 8; i++) begin
            if (gap_seen && src == gpos && deficit != 0) begin
                dc[i] = 16'd0;
                deficit--;
            end else begin
                dc[i] = hw[src & 7];
                src++;
            end
        end
        if (bits < 128 && (bits % 16) != 0) dc[bits / 16] &= 16'hFFFF << (16 - bits % 16);
        for (int i = (bits + 15) / 16; i < 8; i++) dc[i] = 16'd0;
        r.kind = KIND_V6;
        r.hi = {dc[0], dc[1], dc[2], dc[3]};
        r.lo = {dc[4], dc[5], dc[6], dc[7]};
        r.plen = 8'(bits);
        return r;
    endfunction

    function automatic void predict_char(logic [7:0] c, logic last);
        t_result r;
        if (c == CH_COLON) colon_seen = 1'b1;
        if (c == CH_DOT) dot_seen = 1'b1;
        step_v4(c);
        step_v6(c);
        prev_ch = c;
        if (last) begin
            r = '0;
            if (colon_seen && v6_en) r = finish_v6();
            else if (dot_seen) r = finish_v4();
            expected_masks.push_back(r);
            clear_parse();
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_char_req req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) predict_char(i_char_code, i_last_char);
            if (!i_valid || o_ready) begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle) begin
                    req = pending_chars.pop_front();
                    i_valid <= 1'b1;
                    i_char_code <= req.code;
                    i_last_char <= req.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
            if (o_valid && i_ready) begin
                if (expected_masks.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end else begin
                    want = expected_masks.pop_front();
                    if (o_mask_kind !== want.kind) begin
                        $error("mask_kind: expected %0d, got %0d", want.kind, o_mask_kind);
                        errors++;
                    end
                    if (o_address_high !== want.hi) begin
                        $error("address_high: expected %h, got %h", want.hi, o_address_high);
                        errors++;
                    end
                    if (o_address_low !== want.lo) begin
                        $error("address_low: expected %h, got %h", want.lo, o_address_low);
                        errors++;
                    end
                    if (o_prefix_len !== want.plen) begin
                        $error("prefix_len: expected %0d, got %0d", want.plen, o_prefix_len);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic void queue_text(string s);
        t_char_req req;
        for (int i = 0; i < s.len(); i++) begin
            req.code = s[i];
            req.last = (i == s.len() - 1);
            pending_chars.push_back(req);
        end
    endfunction

    function automatic void queue_noise();
        t_char_req req;
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            req.code = 8'($urandom_range(0, 255));
            req.last = (i == n - 1);
            pending_chars.push_back(req);
        end
    endfunction

    function automatic string gen_v4();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            if (k > 0) s = {s, "."};
            case ($urandom_range(9))
                0: ;
                1: s = {s, $sformatf("%0d%0d%0d", $urandom, $urandom, $urandom)};
                2: s = {s, $sformatf("%0d", $urandom_range(256, 999))};
                default: s = {s, $sformatf("%0d", $urandom_range(0, 255))};
            endcase
        end
        case ($urandom_range(5))
            0: if (n < 4) s = {s, ".*"};
            1, 2: s = {s, "/", $sformatf("%0d", $urandom_range(0, 40))};
            3: s = {s, "/", $sformatf("%0d", $urandom_range(0, 2000))};
            default: ;
        endcase
        return s;
    endfunction

    function automatic string gen_v6();
        string s, digits;
        int n, g, d;
        logic [7:0] ch;
        digits = "0123456789abcdefABCDEF";
        s = "";
        n = $urandom_range(1, 8);
        g = $urandom_range(1) ? $urandom_range(0, n) : -1;
        for (int k = 0; k < n; k++) begin
            if (k == g) s = {s, "::"};
            else if (k > 0) s = {s, ":"};
            d = ($urandom_range(19) == 0) ? 5 : $urandom_range(0, 4);
            for (int j = 0; j < d; j++) begin
                ch = digits[$urandom_range(0, 21)];
                s = {s, string'(ch)};
            end
        end
        if (g == n) s = {s, "::"};
        case ($urandom_range(5))
            0: if (g < 0) s = {s, ":*"};
            1, 2: s = {s, "/", $sformatf("%0d", $urandom_range(0, 140))};
            3: s = {s, "/", $sformatf("%0d", $urandom_range(0, 999))};
            default: ;
        endcase
        if (s.len() == 0) s = "::";
        return s;
    endfunction

    function automatic void queue_random_string();
        string s;
        int pick;
        pick = $urandom_range(99);
        if (pick >= 90) begin
            queue_noise();
        end else begin
            s = (pick < 40 || (pick >= 80 && pick < 85)) ? gen_v4() : gen_v6();
            // corrupt one character of a generated mask
            if (pick >= 80) s.putc($urandom_range(0, s.len() - 1), $urandom_range(1, 255));
            queue_text(s);
        end
    endfunction

    // sample at the falling edge so every update of the rising edge has settled
    task automatic drain(int tail);
        while (pending_chars.size() > 0 || i_valid || expected_masks.size() > 0)
            @(negedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        v6_en = data[0];
    endtask

    task automatic random_phase(int chars, int s_idle, int r_idle);
        int target;
        send_idle = s_idle;
        recv_idle = r_idle;
        target = chars / 2;
        while (pending_chars.size() < target) queue_random_string();
        // hold the sender until every result is back
        drain(0);
        while (pending_chars.size() < chars - target) queue_random_string();
        drain(8);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_char_code = 8'd0;
        i_last_char = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        errors = 0;
        send_idle = 0;
        recv_idle = 0;
        v6_en = 1'b1;
        clear_parse();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_text("9.*");
        queue_text("1.2/9");
        queue_text("A:f/5");
        queue_text("::");
        queue_text("1:*");
        queue_text("x");
        queue_text("7:");
        pending_chars.push_back('{8'hFF, 1'b1});
        pending_chars.push_back('{8'h00, 1'b1});
        drain(8);

        apb_write({REG_IPV6_EN, 2'b00}, 32'd0);
        random_phase(370, 35, 74);
        apb_write({REG_IPV6_EN, 2'b00}, 32'hFFFF_FFFF);
        random_phase(370, 74, 35);
        apb_write({REG_IPV6_EN, 2'b00}, 32'hFFFF_FFFE);
        random_phase(180, 0, 0);
        apb_write({REG_IPV6_EN, 2'b00}, 32'd1);
        random_phase(180, 0, 0);

        if (errors == 0 && expected_masks.size() == 0) begin
            $display("ip_netmask_text_parser_unit_test OK");
        end else begin
            $display("ip_netmask_text_parser_unit_test NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("ip_netmask_text_parser_unit_test NOT OK");
        $finish;
    end

endmodule
